// ----- hdl/ise_pkg.sv -----
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types and constants of the insertion sort engine: request and result
// payloads, the cell control group and the controller states.
// ----------------------------------------------------------------------------
package ise_pkg;

    // store depth and element width
    localparam int ISE_DEPTH  = 64;
    localparam int ISE_DATA_W = 32;

    // one incoming request
    typedef struct packed {
        logic signed [ISE_DATA_W-1:0] value;
        logic                         last_in;
    } ise_item_t;

    // one outgoing result
    typedef struct packed {
        logic signed [ISE_DATA_W-1:0] sorted_value;
        logic                         last_out;
        logic                         overflow;
    } ise_result_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } ise_ctrl_t;

    // controller states
    typedef enum logic {
        ISE_LOAD,
        ISE_DRAIN
    } ise_state_t;

endpackage

// ----- hdl/insertion_sort_engine.sv -----
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Sorts a set of signed values in a chain of compare-and-shift cells and
// emits them in ascending order once the last request of the set arrives.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------
//  request   | start, busy               | item   (value, last_in)
//  result    | result_valid              | result (sorted_value, last_out,
//            |                           |         overflow)
//
//  Loading takes one request per cycle while busy is low: every cell compares
//  in parallel and the larger values move up one place in the same cycle.
//  After the last request, busy stays high while the chain shifts down and
//  emits one result per cycle, until every stored value has been emitted.
//  Reset empties the store and clears the overflow flag; no clearing pass.
//  Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module insertion_sort_engine
    import ise_pkg::*;
#(
    parameter int DEPTH = ISE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ise_item_t   item,
    output logic        result_valid,
    output ise_result_t result
);

    localparam int              CW         = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]   FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0]   ONE_COUNT  = CW'(1);

    ise_state_t     state_reg;
    ise_state_t     state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           overflow_reg;
    logic           overflow_next;

    ise_ctrl_t      ctrl;
    logic           accept;
    logic           full;
    logic           draining;

    logic signed [ISE_DATA_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]             cell_ins;
    logic [DEPTH-1:0]             occupied;

    // request handshake
    assign accept = start && !busy;
    assign full   = (count_reg == FULL_COUNT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ISE_LOAD:
            begin
                if (accept && item.last_in)
                begin
                    state_next = ISE_DRAIN;
                end
            end
            ISE_DRAIN:
            begin
                if (count_reg == ONE_COUNT)
                begin
                    state_next = ISE_LOAD;
                end
            end
            default:
            begin
                state_next = ISE_LOAD;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        draining = 1'b0;
        case (state_reg)
            ISE_LOAD:  draining = 1'b0;
            ISE_DRAIN: draining = 1'b1;
            default:   draining = 1'b0;
        endcase
    end

    assign busy         = draining;
    assign result_valid = draining;
    assign ctrl.insert  = accept && !full;
    assign ctrl.shift   = draining;

    // element count and overflow flag
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + ONE_COUNT;
        end
        else if (accept)
        begin
            overflow_next = 1'b1;
        end
        if (draining)
        begin
            count_next = count_reg - ONE_COUNT;
            if (count_reg == ONE_COUNT)
            begin
                overflow_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ISE_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [ISE_DATA_W-1:0] left_value;
        logic                         left_ins;
        logic signed [ISE_DATA_W-1:0] right_value;

        assign occupied[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            assign left_value = item.value;
            assign left_ins   = 1'b0;
        end
        else
        begin : g_inner
            assign left_value = cell_value[i-1];
            assign left_ins   = cell_ins[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign right_value = '0;
        end
        else
        begin : g_below
            assign right_value = cell_value[i+1];
        end

        ise_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_value   (item.value),
            .occupied    (occupied[i]),
            .left_value  (left_value),
            .left_ins    (left_ins),
            .right_value (right_value),
            .value       (cell_value[i]),
            .ins         (cell_ins[i])
        );
    end

    // result from the bottom of the chain
    assign result.sorted_value = cell_value[0];
    assign result.last_out     = (count_reg == ONE_COUNT);
    assign result.overflow     = overflow_reg;

`ifndef SYNTHESIS
    // store never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("element count beyond store depth");

    // a request that finds the store full raises the overflow flag
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && full |=> overflow_reg)
        else $error("dropped value did not set overflow");

    // results run without gaps until the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_out |=> result_valid)
        else $error("gap in result run");

    // the final result returns the block to loading with an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_out |=> !busy && (count_reg == '0) && !overflow_reg)
        else $error("block not empty after final result");
`endif

endmodule

// ----- hdl/ise_cell.sv -----
// ----------------------------------------------------------------------------
// ise_cell
// One place of the sorted chain. Compares its stored value with the incoming
// one, takes the left neighbor's value or the new value on insertion, and
// takes the right neighbor's value while the chain drains.
// ----------------------------------------------------------------------------
module ise_cell
    import ise_pkg::*;
(
    input  logic                         clk,
    input  ise_ctrl_t                    ctrl,
    input  logic signed [ISE_DATA_W-1:0] new_value,
    input  logic                         occupied,
    input  logic signed [ISE_DATA_W-1:0] left_value,
    input  logic                         left_ins,
    input  logic signed [ISE_DATA_W-1:0] right_value,
    output logic signed [ISE_DATA_W-1:0] value,
    output logic                         ins
);

    logic signed [ISE_DATA_W-1:0] value_reg;
    logic signed [ISE_DATA_W-1:0] value_next;

    // this place moves up when it is empty or holds a larger value
    always_comb
    begin
        ins = !occupied || (value_reg > new_value);
    end

    // next stored value
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
        end
        else if (ctrl.insert && ins)
        begin
            value_next = left_ins ? left_value : new_value;
        end
    end

    // stored value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
